// ----- hdl/generational_handle_table_assert.svh -----
// assertion macros for the generational handle table
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define GHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ght check failed");
`define GHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ght check failed");
`else
`define GHT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GHT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/ght_pkg.sv -----
// shared types and constants for the generational handle table
package ght_pkg;

  localparam int DEF_SLOTS     = 16;
  localparam int DEF_DATA_BITS = 32;
  localparam int GEN_W         = 8;
  localparam int ID_W          = 16;
  localparam int CMP_W         = 9;
  localparam int SIU_W         = 5;
  localparam logic [SIU_W-1:0] SIU_RESET = 5'd16;

  typedef enum logic [1:0] {
    KIND_FIND   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_STALE   = 2'd2,
    STAT_NOFREE  = 2'd3
  } status_t;

  typedef enum logic {
    CFG_TABLE_ID     = 1'b0,
    CFG_SLOTS_IN_USE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic set;
    logic clr;
  } slot_upd_t;

  typedef struct packed {
    logic valid;
    logic gen_ok;
  } slot_info_t;

endpackage

// ----- hdl/ght_ram.sv -----
// generic single-port-write ram with registered read
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/ght_alloc.sv -----
// slot valid bits, free slot search and occupancy count
module ght_alloc #(
  parameter int SLOTS = ght_pkg::DEF_SLOTS,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [ght_pkg::CMP_W-1:0] eff_size,
  input  logic [IDX_W-1:0]         idx,
  input  ght_pkg::slot_upd_t       upd,
  output ght_pkg::slot_info_t      info,
  output logic                     free_found,
  output logic [IDX_W-1:0]         free_idx,
  output logic [CNT_W-1:0]         occ_next
);

  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] valid_nxt;
  logic [SLOTS-1:0] genw_r;
  logic [SLOTS-1:0] genw_nxt;
  logic [CNT_W-1:0] cnt_r;

  // lowest free slot inside the active range
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i] && (ght_pkg::CMP_W'(i) < eff_size)) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign info.valid  = valid_r[idx];
  assign info.gen_ok = genw_r[idx];

  always_comb begin
    valid_nxt = valid_r;
    genw_nxt  = genw_r;
    occ_next  = cnt_r;
    if (upd.set) begin
      valid_nxt[idx] = 1'b1;
      genw_nxt[idx]  = 1'b1;
      occ_next       = cnt_r + CNT_W'(1);
    end else if (upd.clr) begin
      valid_nxt[idx] = 1'b0;
      genw_nxt[idx]  = 1'b1;
      if (valid_r[idx]) begin
        occ_next = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      genw_r  <= '0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      genw_r  <= genw_nxt;
      cnt_r   <= occ_next;
    end
  end

endmodule

// ----- hdl/generational_handle_table.sv -----
// top level of the generational handle table
//
// usage: requests enter on the in_ stream (kind in in_tuser, handle and data in
// in_tdata); one result leaves on the out_ stream per request, in order.
// kinds: find checks id, index range, valid bit and generation and returns the
// data; add takes the lowest free slot below slots_in_use and returns a new
// handle; delete frees the slot and bumps its generation.
// the accepting edge also starts the slot memory read; checks and
// update run in the read state and the result is registered when that state
// advances, which waits until the output register is free. a new request is
// taken only after the read-modify-write of the combined data and generation
// memory is done. a request is taken while an earlier result still waits in the
// output register; the read-modify-write then holds until that result is
// taken, so a stalled receiver holds back the stream with no loss.
// reset: table empty, all generations zero, table_id 0, slots_in_use 16; no
// clearing pass. user makes cfg writes while no request is in flight; unenforced.
`include "generational_handle_table_assert.svh"
module generational_handle_table #(
  parameter int SLOTS     = ght_pkg::DEF_SLOTS,
  parameter int DATA_BITS = ght_pkg::DEF_DATA_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // handle_in, data_in
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // handle_out, data_out, occupied, zero pad
  output logic [1:0]  out_tuser   // status
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int GEN_W = ght_pkg::GEN_W;
  localparam int CMP_W = ght_pkg::CMP_W;
  localparam int MEM_W = DATA_BITS + GEN_W;

  // configuration
  logic [ght_pkg::ID_W-1:0]  table_id_r;
  logic [ght_pkg::SIU_W-1:0] siu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_id_r <= '0;
      siu_r      <= ght_pkg::SIU_RESET;
    end else if (cfg_we) begin
      unique case (ght_pkg::cfg_idx_t'(cfg_addr))
        ght_pkg::CFG_TABLE_ID:     table_id_r <= cfg_wdata;
        ght_pkg::CFG_SLOTS_IN_USE: siu_r      <= ght_pkg::SIU_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  logic [CMP_W-1:0] eff_size;
  assign eff_size = ({4'b0, siu_r} > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : {4'b0, siu_r};

  // request fields
  ght_pkg::kind_t        in_kind;
  logic [7:0]            in_idx8;
  logic [GEN_W-1:0]      in_gen;
  logic [ght_pkg::ID_W-1:0] in_id;
  logic [31:0]           in_data;
  logic                  in_fire;

  assign in_kind = ght_pkg::kind_t'(in_tuser);
  assign in_idx8 = in_tdata[7:0];
  assign in_gen  = in_tdata[15:8];
  assign in_id   = in_tdata[31:16];
  assign in_data = in_tdata[63:32];
  assign in_fire = in_tvalid && in_tready;

  // control
  ght_pkg::state_t state_r, state_nxt;
  logic            advance;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ght_pkg::ST_IDLE: if (in_fire) state_nxt = ght_pkg::ST_READ;
      ght_pkg::ST_READ: if (advance) state_nxt = ght_pkg::ST_IDLE;
      default: state_nxt = ght_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    advance   = 1'b0;
    unique case (state_r)
      ght_pkg::ST_IDLE: in_tready = 1'b1;
      ght_pkg::ST_READ: advance = !out_tvalid || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ght_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // slot allocation
  ght_pkg::slot_upd_t  upd;
  ght_pkg::slot_info_t info;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic [CNT_W-1:0]    occ_next;
  logic [IDX_W-1:0]    idx_r;

  ght_alloc #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_alloc (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_size   (eff_size),
    .idx        (idx_r),
    .upd        (upd),
    .info       (info),
    .free_found (free_found),
    .free_idx   (free_idx),
    .occ_next   (occ_next)
  );

  // pre-checks at acceptance
  logic                  in_range;
  logic                  pre_ok;
  ght_pkg::status_t      pre_status;
  logic [IDX_W-1:0]      sel_idx;

  assign in_range = {1'b0, in_idx8} < eff_size;

  always_comb begin
    pre_ok     = 1'b0;
    pre_status = ght_pkg::STAT_INVALID;
    sel_idx    = IDX_W'(in_idx8);
    unique case (in_kind)
      ght_pkg::KIND_FIND: pre_ok = (in_id == table_id_r) && in_range;
      ght_pkg::KIND_ADD: begin
        sel_idx = free_idx;
        pre_ok  = free_found;
        if (!free_found) begin
          pre_status = ght_pkg::STAT_NOFREE;
        end
      end
      ght_pkg::KIND_DELETE: pre_ok = in_range;
      default: pre_ok = 1'b0;
    endcase
  end

  ght_pkg::kind_t   op_r;
  logic             pre_ok_r;
  ght_pkg::status_t pre_status_r;
  logic [GEN_W-1:0] hgen_r;
  logic [31:0]      data_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r         <= in_kind;
      pre_ok_r     <= pre_ok;
      pre_status_r <= pre_status;
      hgen_r       <= in_gen;
      data_r       <= in_data;
      idx_r        <= sel_idx;
    end
  end

  // slot memory: generation above data
  logic             mem_we;
  logic [MEM_W-1:0] mem_wdata;
  logic [MEM_W-1:0] mem_rdata;

  ght_ram #(
    .WIDTH (MEM_W),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_r),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (sel_idx),
    .rdata (mem_rdata)
  );

  // read-modify-write
  logic [GEN_W-1:0] gen_cur;
  ght_pkg::status_t res_status;
  logic [31:0]      res_hout;
  logic [31:0]      res_dout;

  assign gen_cur = info.gen_ok ? mem_rdata[DATA_BITS +: GEN_W] : '0;

  always_comb begin
    res_status = pre_status_r;
    res_hout   = '0;
    res_dout   = '0;
    upd        = '0;
    mem_we     = 1'b0;
    mem_wdata  = {gen_cur, {DATA_BITS{1'b0}}};
    if (pre_ok_r) begin
      res_status = ght_pkg::STAT_OK;
      unique case (op_r)
        ght_pkg::KIND_FIND: begin
          if (!info.valid || (gen_cur != hgen_r)) begin
            res_status = ght_pkg::STAT_STALE;
          end else begin
            res_dout = 32'(mem_rdata[DATA_BITS-1:0]);
          end
        end
        ght_pkg::KIND_ADD: begin
          upd.set   = advance;
          mem_we    = advance;
          mem_wdata = {gen_cur, DATA_BITS'(data_r)};
          res_hout  = {table_id_r, gen_cur, 8'(idx_r)};
        end
        ght_pkg::KIND_DELETE: begin
          upd.clr   = advance;
          mem_we    = advance;
          mem_wdata = {GEN_W'(gen_cur + 1'b1), {DATA_BITS{1'b0}}};
        end
        default: res_status = ght_pkg::STAT_INVALID;
      endcase
    end
  end

  // output register
  logic             out_valid_r;
  ght_pkg::status_t out_status_r;
  logic [31:0]      out_hout_r;
  logic [31:0]      out_dout_r;
  logic [4:0]       out_occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= res_status;
      out_hout_r   <= res_hout;
      out_dout_r   <= res_dout;
      out_occ_r    <= 5'(occ_next);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, out_occ_r, out_dout_r, out_hout_r};
  assign out_tuser  = out_status_r;

  `GHT_ASSERT_NXT(a_accept_reads, clk, rst_n, in_fire, state_r == ght_pkg::ST_READ)
  `GHT_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_next <= CNT_W'(SLOTS))
  `GHT_ASSERT_IMP(a_out_after_read, clk, rst_n, $rose(out_valid_r), $past(state_r == ght_pkg::ST_READ))
  `GHT_ASSERT_IMP(a_write_in_read, clk, rst_n, mem_we, advance && pre_ok_r)

endmodule
